### sv/tds_pkg.sv
package tds_pkg;

	localparam int ADC_W  = 12;
	localparam int TEMP_W = 12;
	localparam int V_W    = 18;
	localparam int RAW_W  = 18;
	localparam int COMP_W = 15;
	localparam int K_W    = 16;
	localparam int DSR_W  = 12;
	localparam int DVD_W  = 28;
	localparam int CURVE_STAGES = 7;

	localparam logic [K_W-1:0]    K_RESET   = 16'd4096;
	localparam logic [K_W-1:0]    K_MAX     = 16'd40959;
	localparam logic [COMP_W-1:0] CURVE_MAX = 15'd22400;

	typedef struct packed {
		logic [ADC_W-1:0]         adc_sample;
		logic signed [TEMP_W-1:0] temperature_sixteenths;
	} tds_in_t;

	typedef struct packed {
		logic [V_W-1:0]    probe_voltage;
		logic [RAW_W-1:0]  raw_tds;
		logic [COMP_W-1:0] compensated_tds;
	} tds_out_t;

	typedef struct packed {
		logic [V_W-1:0] v;
		logic           neg;
	} tds_side_t;

endpackage

### sv/tds_vconv.sv
module tds_vconv import tds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  tds_in_t          in_item,
	output logic             out_vld,
	output tds_side_t        out_side,
	output logic [DSR_W-1:0] out_dsr
);

	// floor(2^44 / 13650)
	localparam logic [30:0] RECIP = 31'd1288804838;

	logic [15:0] s11;
	logic [31:0] num;
	logic [62:0] prod;

	logic                     vld_s1;
	logic [62:0]              prod_s1;
	logic [31:0]              num_s1;
	logic signed [TEMP_W-1:0] temp_s1;

	logic [V_W-1:0]     q0;
	logic [31:0]        qm;
	logic [31:0]        rem;
	logic [V_W-1:0]     v;
	logic signed [12:0] d;
	logic               neg;
	logic               zero;
	logic [DSR_W-1:0]   dsr;

	assign s11  = {4'd0, in_item.adc_sample} * 16'd11;
	assign num  = {s11, 16'd0} + 32'd6825;
	assign prod = {31'd0, num} * {32'd0, RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_vld;
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
			num_s1  <= num;
			temp_s1 <= in_item.temperature_sixteenths;
		end
	end

	// quotient estimate is exact or one low
	assign q0   = prod_s1[61:44];
	assign qm   = {14'd0, q0} * 32'd13650;
	assign rem  = num_s1 - qm;
	assign v    = q0 + {17'd0, (rem >= 32'd13650)};
	assign d    = {temp_s1[TEMP_W-1], temp_s1} + 13'sd400;
	assign neg  = d[12];
	assign zero = (d == 13'sd0);
	// zero or negative factor divides by 800 to give V back
	assign dsr  = (neg || zero) ? 12'd800 : d[DSR_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			out_side.v   <= v;
			out_side.neg <= neg;
			out_dsr      <= dsr;
		end
	end

endmodule

### sv/tds_div.sv
module tds_div import tds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  tds_side_t        in_side,
	input  logic [DSR_W-1:0] in_dsr,
	output logic             out_vld,
	output tds_side_t        out_side,
	output logic [DVD_W-1:0] out_quo
);

	logic [DVD_W-1:0] dvd0;

	logic             vld_s  [0:DVD_W];
	tds_side_t        side_s [0:DVD_W];
	logic [DSR_W-1:0] dsr_s  [0:DVD_W];
	logic [DSR_W-1:0] rem_s  [0:DVD_W];
	logic [DVD_W-1:0] dq_s   [0:DVD_W];

	assign dvd0 = {10'd0, in_side.v} * 28'd800 + {17'd0, in_dsr[DSR_W-1:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			dsr_s[0]  <= in_dsr;
			rem_s[0]  <= '0;
			dq_s[0]   <= dvd0;
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar i = 0; i < DVD_W; i++) begin : g_step
		logic [DSR_W:0] trial;
		logic [DSR_W:0] diff;
		logic           ge;

		assign trial = {rem_s[i], dq_s[i][DVD_W-1]};
		assign diff  = trial - {1'b0, dsr_s[i]};
		assign ge    = (trial >= {1'b0, dsr_s[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i+1] <= side_s[i];
				dsr_s[i+1]  <= dsr_s[i];
				rem_s[i+1]  <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
				dq_s[i+1]   <= {dq_s[i][DVD_W-2:0], ge};
			end
		end
	end

	assign out_vld  = vld_s[DVD_W];
	assign out_side = side_s[DVD_W];
	assign out_quo  = dq_s[DVD_W];

endmodule

### sv/tds_curve.sv
module tds_curve import tds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [V_W-1:0]   v_in,
	input  logic             sat_in,
	input  logic [K_W-1:0]   k_gain,
	output logic             out_vld,
	output logic [RAW_W-1:0] g_out
);

	localparam logic signed [31:0] S_BIAS = 32'sd838402048;
	localparam logic signed [50:0] Q_BIAS = {3'd0, 16'd42870, 32'd0};
	localparam logic [51:0]        Y_RND  = 52'd13421772800;
	localparam logic [21:0]        W_SAT  = 22'd560025;
	// ceil(2^25 / 25), exact for the clamped range
	localparam logic [20:0]        RECIP25 = 21'd1342178;

	logic [6:0] vld_s;

	logic [30:0]        m6671;
	logic signed [50:0] sv;
	logic signed [50:0] q;
	logic [32:0]        q16;
	logic [50:0]        p;
	logic [51:0]        ysum;
	logic [21:0]        w;
	logic [40:0]        wm;
	logic [COMP_W-1:0]  y;
	logic [31:0]        g;

	logic signed [31:0] s_s1;
	logic [V_W-1:0]     v_s1, v_s2, v_s3;
	logic               sat_s1, sat_s2, sat_s3, sat_s4, sat_s5;
	logic signed [50:0] sv_s2;
	logic [32:0]        q16_s3;
	logic [50:0]        p_s4;
	logic [19:0]        w_s5;
	logic [COMP_W-1:0]  y_s6;
	logic [RAW_W-1:0]   g_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[5:0], in_vld};
		end
	end

	assign m6671 = {13'd0, v_in} * 31'd6671;
	assign sv    = s_s1 * $signed({1'b0, v_s1});
	assign q     = sv_s2 + Q_BIAS;
	assign q16   = q[50] ? 33'd0 : q[48:16];
	assign p     = {33'd0, v_s3} * {18'd0, q16_s3};
	assign ysum  = {1'b0, p_s4} + Y_RND;
	assign w     = ysum[51:30];
	assign wm    = {21'd0, w_s5} * {20'd0, RECIP25};
	assign y     = sat_s5 ? CURVE_MAX : wm[39:25];
	assign g     = {17'd0, y_s6} * {16'd0, k_gain} + 32'd2048;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1   <= $signed({1'b0, m6671}) - S_BIAS;
			v_s1   <= v_in;
			sat_s1 <= sat_in;

			sv_s2  <= sv;
			v_s2   <= v_s1;
			sat_s2 <= sat_s1;

			q16_s3 <= q16;
			v_s3   <= v_s2;
			sat_s3 <= sat_s2;

			p_s4   <= p;
			sat_s4 <= sat_s3;

			w_s5   <= w[19:0];
			sat_s5 <= sat_s4 || (w >= W_SAT);

			y_s6   <= y;

			g_s7   <= g[29:12];
		end
	end

	assign out_vld = vld_s[6];
	assign g_out   = g_s7;

endmodule

### sv/tds_conductivity_converter_core.sv
// Pipeline order from input accept to result valid: voltage conversion,
//   divider, curve and gain, output register.
// Throughput: one item per clock; the whole pipeline holds while a result waits.
// Reset: arst_n async active low clears all valid bits and sets k_gain to 4096.
module tds_conductivity_converter_core import tds_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tds_in_t        in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output tds_out_t       out_item,
	input  logic           cfg_we,
	input  logic [K_W-1:0] cfg_wdata
);

	logic           en;
	logic [K_W-1:0] k_gain_q;

	logic             vc_vld;
	tds_side_t        vc_side;
	logic [DSR_W-1:0] vc_dsr;

	logic             dv_vld;
	tds_side_t        dv_side;
	logic [DVD_W-1:0] dv_quo;

	logic             raw_vld;
	logic             cmp_vld;
	logic [RAW_W-1:0] raw_g;
	logic [RAW_W-1:0] cmp_g;

	tds_side_t side_d [0:CURVE_STAGES-1];

	logic [COMP_W-1:0] comp;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_gain_q <= K_RESET;
		end else if (cfg_we && cfg_wdata != '0 && cfg_wdata <= K_MAX) begin
			k_gain_q <= cfg_wdata;
		end
	end

	tds_vconv u_vconv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (in_valid),
		.in_item  (in_item),
		.out_vld  (vc_vld),
		.out_side (vc_side),
		.out_dsr  (vc_dsr)
	);

	tds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vc_vld),
		.in_side  (vc_side),
		.in_dsr   (vc_dsr),
		.out_vld  (dv_vld),
		.out_side (dv_side),
		.out_quo  (dv_quo)
	);

	tds_curve u_curve_raw (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (dv_vld),
		.v_in    (dv_side.v),
		.sat_in  (1'b0),
		.k_gain  (k_gain_q),
		.out_vld (raw_vld),
		.g_out   (raw_g)
	);

	tds_curve u_curve_cmp (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (dv_vld),
		.v_in    (dv_quo[V_W-1:0]),
		.sat_in  (dv_quo[DVD_W-1:V_W] != '0),
		.k_gain  (k_gain_q),
		.out_vld (cmp_vld),
		.g_out   (cmp_g)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= dv_side;
			for (int i = 1; i < CURVE_STAGES; i++) begin
				side_d[i] <= side_d[i-1];
			end
		end
	end

	always_comb begin
		if (side_d[CURVE_STAGES-1].neg) begin
			comp = '0;
		end else if (cmp_g > {3'd0, CURVE_MAX}) begin
			comp = CURVE_MAX;
		end else begin
			comp = cmp_g[COMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= raw_vld && cmp_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item.probe_voltage   <= side_d[CURVE_STAGES-1].v;
			out_item.raw_tds         <= raw_g;
			out_item.compensated_tds <= comp;
		end
	end

endmodule
